FILE: hw/rtl/pcct_pkg.sv
// shared types, codes and count arithmetic for the client connection count table
package pcct_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;
    localparam int unsigned KEY_W               = 64;
    localparam int unsigned COUNT_W             = 16;

    localparam logic [1:0] CMD_OPEN  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] addr_high;
        logic [KEY_W-1:0] addr_low;
    } item_t;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key_high;
        logic [KEY_W-1:0]   key_low;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // saturating open, floored close; query and the spare code leave it alone
    function automatic logic [COUNT_W-1:0] count_step(input logic [1:0] cmd,
                                                      input logic [COUNT_W-1:0] cur);
        logic [COUNT_W-1:0] nxt;
        nxt = cur;
        case (cmd)
            CMD_OPEN:  if (cur != COUNT_MAX) nxt = cur + COUNT_W'(1);
            CMD_CLOSE: if (cur != '0) nxt = cur - COUNT_W'(1);
            CMD_QUERY: nxt = cur;
            default:   nxt = cur;
        endcase
        return nxt;
    endfunction

endpackage

FILE: hw/rtl/pcct_entry_ram.sv
// entry store: one write port, one read port with registered read data
module pcct_entry_ram #(
    parameter int unsigned DEPTH = pcct_pkg::TABLE_DEPTH_DEFAULT,
    parameter int unsigned AW    = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  pcct_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output pcct_pkg::entry_t rd_data
);
    import pcct_pkg::*;

    entry_t store_reg [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/pcct_ctrl.sv
// scan sequencer: walks the filled entries through one key comparator, then updates
module pcct_ctrl #(
    parameter int unsigned DEPTH = pcct_pkg::TABLE_DEPTH_DEFAULT,
    parameter int unsigned AW    = 10,
    parameter int unsigned FW    = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pcct_pkg::item_t   request,
    output logic              busy,
    output logic              done,
    output pcct_pkg::result_t response,
    output logic              ram_wr_en,
    output logic [AW-1:0]     ram_wr_addr,
    output pcct_pkg::entry_t  ram_wr_data,
    output logic              ram_rd_en,
    output logic [AW-1:0]     ram_rd_addr,
    input  pcct_pkg::entry_t  ram_rd_data
);
    import pcct_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t             state_reg,     state_next;
    item_t              item_reg,      item_next;
    logic [FW-1:0]      rd_idx_reg,    rd_idx_next;
    logic [AW-1:0]      cmp_idx_reg,   cmp_idx_next;
    logic [FW-1:0]      fill_reg,      fill_next;
    logic               found_reg,     found_next;
    logic [AW-1:0]      slot_reg,      slot_next;
    logic [COUNT_W-1:0] old_count_reg, old_count_next;
    logic               done_reg,      done_next;
    result_t            result_reg,    result_next;

    logic               key_hit;
    logic [COUNT_W-1:0] new_count;

    // valid entries always form a prefix, so the fill count stands in for valid marks
    assign key_hit = (ram_rd_data.key_high == item_reg.addr_high) &&
                     (ram_rd_data.key_low == item_reg.addr_low);

    assign new_count = count_step(item_reg.cmd, found_reg ? old_count_reg : '0);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        fill_next      = fill_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        old_count_next = old_count_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = slot_reg;
        ram_wr_data    = '{key_high: item_reg.addr_high,
                           key_low:  item_reg.addr_low,
                           count:    new_count};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = request;
                    if (fill_reg == '0)
                    begin
                        found_next = 1'b0;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = '0;
                        cmp_idx_next = '0;
                        rd_idx_next  = FW'(1);
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (key_hit)
                begin
                    found_next     = 1'b1;
                    slot_next      = cmp_idx_reg;
                    old_count_next = ram_rd_data.count;
                    state_next     = ST_UPDATE;
                end
                else if (rd_idx_reg < fill_reg)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = rd_idx_reg[AW-1:0];
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next  = rd_idx_reg + FW'(1);
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (found_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = slot_reg;
                    result_next = '{status: STATUS_OK, count: new_count};
                end
                else if (fill_reg < FW'(DEPTH))
                begin
                    // claim the first free entry
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = fill_reg[AW-1:0];
                    fill_next   = fill_reg + FW'(1);
                    result_next = '{status: STATUS_OK, count: new_count};
                end
                else
                begin
                    result_next = '{status: STATUS_FULL, count: '0};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            old_count_reg <= '0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            slot_reg      <= slot_next;
            old_count_reg <= old_count_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = result_reg;

endmodule

FILE: hw/rtl/per_client_connection_count_table_top.sv
// top level of the per-client connection count table
//
//  channel   signals                    handshake
//  -------   ------------------------   -------------------------------------
//  command   start, busy, request       taken at an edge with start high, busy low
//  result    done, response             one cycle with done high, cannot stall
//
// an item is compared against up to the fill count of entries, fewer when the key matches
// early, and the next item is taken only once this one is through; the single ram read
// port and the one key comparator make the scan walk the entries one by one
// reset clears the fill count and the sequencer; entry contents need no clearing
// the response is shown in the cycle after the update, the same cycle busy drops
module per_client_connection_count_table_top #(
    parameter int unsigned TABLE_DEPTH = pcct_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pcct_pkg::item_t   request,
    output logic              busy,
    output logic              done,
    output pcct_pkg::result_t response
);
    import pcct_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    entry_t        ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    entry_t        ram_rd_data;

    pcct_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .FW    (FW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .busy        (busy),
        .done        (done),
        .response    (response),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    pcct_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: bench/per_client_connection_count_table_top_tb.sv
// self-checking bench for the per-client connection count table: driver, monitor and predictor
module per_client_connection_count_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pcct_pkg::*;

    localparam int unsigned DEPTH       = TABLE_DEPTH_DEFAULT;
    localparam logic [1:0]  CMD_SPARE   = 2'd3;
    localparam int          IDLE_LIGHT  = 34;
    localparam int          IDLE_HEAVY  = 54;
    localparam int          IDLE_NONE   = 0;
    localparam int          RANDOM_CMDS = 563;
    localparam int          QUIET_LIMIT = 20000;

    typedef struct {
        item_t item;
        int    idle_pct;
        bit    hold;
    } cmd_job_t;

    logic    clk     = 1'b0;
    logic    rst_n   = 1'b0;
    logic    start   = 1'b0;
    item_t   request = '0;
    logic    busy;
    logic    done;
    result_t response;

    cmd_job_t            pending_cmds[$];
    result_t             expected_counts[$];
    logic [2*KEY_W-1:0]  key_pool[$];

    // predictor copy of the table
    bit                  tbl_valid [DEPTH];
    logic [KEY_W-1:0]    tbl_high  [DEPTH];
    logic [KEY_W-1:0]    tbl_low   [DEPTH];
    logic [COUNT_W-1:0]  tbl_count [DEPTH];

    int n_total    = 0;
    int n_sent     = 0;
    int n_pending  = 0;
    int n_checked  = 0;
    int n_full     = 0;
    int n_ceiling  = 0;
    int n_floor    = 0;
    int errors     = 0;
    int quiet      = 0;

    per_client_connection_count_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // look up or claim an entry, then apply the command to its count; report full when none is free
    function automatic result_t predict_count(input item_t it);
        int                 slot;
        int                 free_slot;
        logic [COUNT_W-1:0] c;
        result_t            r;
        slot      = -1;
        free_slot = -1;
        for (int i = 0; i < int'(DEPTH) && slot < 0; i++)
        begin
            if (!tbl_valid[i])
            begin
                if (free_slot < 0)
                    free_slot = i;
            end
            else if (tbl_high[i] == it.addr_high && tbl_low[i] == it.addr_low)
                slot = i;
        end
        if (slot < 0 && free_slot >= 0)
        begin
            slot = free_slot;
            tbl_valid[slot] = 1'b1;
            tbl_high[slot]  = it.addr_high;
            tbl_low[slot]   = it.addr_low;
            tbl_count[slot] = '0;
        end
        if (slot < 0)
        begin
            r.status = STATUS_FULL;
            r.count  = '0;
        end
        else
        begin
            c = tbl_count[slot];
            if (it.cmd == CMD_OPEN && c < COUNT_MAX)
                c = c + 1'b1;
            else if (it.cmd == CMD_CLOSE && c > 0)
                c = c - 1'b1;
            tbl_count[slot] = c;
            r.status = STATUS_OK;
            r.count  = c;
        end
        return r;
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input logic [2*KEY_W-1:0] key,
                             input int idle_pct, input bit hold);
        cmd_job_t job;
        bit       known;
        known = 1'b0;
        foreach (key_pool[k])
            if (key_pool[k] == key)
                known = 1'b1;
        if (!known && key_pool.size() < DEPTH)
            key_pool.push_back(key);
        job.item.cmd       = cmd;
        job.item.addr_high = key[2*KEY_W-1:KEY_W];
        job.item.addr_low  = key[KEY_W-1:0];
        job.idle_pct       = idle_pct;
        job.hold           = hold;
        pending_cmds.push_back(job);
    endtask

    function automatic logic [1:0] pick_cmd();
        int w;
        w = $urandom_range(99);
        if (w < 40)
            return CMD_OPEN;
        else if (w < 75)
            return CMD_CLOSE;
        else if (w < 90)
            return CMD_QUERY;
        return CMD_SPARE;
    endfunction

    function automatic logic [2*KEY_W-1:0] fresh_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // driver: one item at a time, random gaps, optional wait until no item is outstanding
    always @(posedge clk or negedge rst_n)
    begin : drive
        cmd_job_t nxt;
        bit       took;
        bit       go;
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            took = start && !busy;
            if (!start || took)
            begin
                go = 1'b0;
                if (pending_cmds.size() != 0)
                begin
                    go = ($urandom_range(99) >= pending_cmds[0].idle_pct);
                    if (pending_cmds[0].hold && (took || n_pending != 0))
                        go = 1'b0;
                end
                if (go)
                begin
                    nxt = pending_cmds.pop_front();
                    start   <= 1'b1;
                    request <= nxt.item;
                    n_sent  <= n_sent + 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: results first (they belong to earlier items), then the item taken now
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        bit      acc;
        bit      got;
        if (!rst_n)
        begin
            n_pending <= 0;
            quiet = 0;
        end
        else
        begin
            acc = start && !busy;
            got = done;
            if (got)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, actual status %0d count %0d",
                             $time, response.status, response.count);
                    errors++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (response.status !== want.status)
                    begin
                        $display("%0t ns: status mismatch, expected %0d actual %0d",
                                 $time, want.status, response.status);
                        errors++;
                    end
                    if (response.count !== want.count)
                    begin
                        $display("%0t ns: count mismatch, expected %0d actual %0d",
                                 $time, want.count, response.count);
                        errors++;
                    end
                    n_checked++;
                    if (want.status == STATUS_FULL)
                        n_full++;
                    else if (want.count == COUNT_MAX)
                        n_ceiling++;
                    else if (want.count == '0)
                        n_floor++;
                end
            end
            if (acc)
                expected_counts.push_back(predict_count(request));
            n_pending <= n_pending + int'(acc) - int'(got);
            if (acc || got)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t ns: no item or result for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [2*KEY_W-1:0] key;
        logic [2*KEY_W-1:0] k_zero;
        logic [2*KEY_W-1:0] k_ones;
        int                 idle;
        int                 r;

        k_zero = '0;
        k_ones = '1;

        // directed: unknown keys under every command, floor, spare code, half-key near misses
        queue_cmd(CMD_QUERY, k_zero, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_OPEN,  k_zero, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_CLOSE, k_zero, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_CLOSE, k_zero, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_SPARE, k_zero, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_OPEN,  k_ones, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_OPEN,  k_ones, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_SPARE, k_ones, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_CLOSE, {{KEY_W{1'b1}}, {KEY_W{1'b0}}}, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_OPEN,  {{KEY_W{1'b0}}, {KEY_W{1'b1}}}, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_QUERY, k_ones ^ (128'd1 << 127), IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_OPEN,  k_ones ^ 128'd1, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_SPARE, {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
                  IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_OPEN,  {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
                  IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_CLOSE, {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
                  IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_QUERY, k_ones, IDLE_LIGHT, 1'b0);
        queue_cmd(CMD_QUERY, {{KEY_W{1'b1}}, {KEY_W{1'b0}}}, IDLE_LIGHT, 1'b0);

        // random traffic, mostly on keys already held, some near misses and new keys
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i < RANDOM_CMDS / 3)
                idle = IDLE_LIGHT;
            else if (i < 2 * RANDOM_CMDS / 3)
                idle = IDLE_HEAVY;
            else
                idle = IDLE_NONE;
            r = $urandom_range(99);
            key = key_pool[$urandom_range(key_pool.size() - 1)];
            if (r >= 90)
                key = fresh_key();
            else if (r >= 75)
                key = key ^ (128'd1 << $urandom_range(2 * KEY_W - 1));
            queue_cmd(pick_cmd(), key, idle, i == RANDOM_CMDS / 2);
        end

        n_total = pending_cmds.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(n_sent == n_total && !start && n_pending == 0))
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);

        $display("%0d items checked on a partly filled table; %0d refused as table full,",
                 n_checked, n_full);
        $display("%0d at the count ceiling and %0d at zero", n_ceiling, n_floor);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pcct_pkg.sv
hw/rtl/pcct_entry_ram.sv
hw/rtl/pcct_ctrl.sv
hw/rtl/per_client_connection_count_table_top.sv
bench/per_client_connection_count_table_top_tb.sv
